@@ src/ship_rrip_pkg.sv @@
package ship_rrip_pkg;

  // default geometry
  localparam int DEF_SETS         = 1024;
  localparam int DEF_WAYS         = 16;
  localparam int DEF_SHCT_ENTRIES = 16384;

  // payload widths
  localparam int SET_IDX_W = 10;
  localparam int WAY_IN_W  = 4;
  localparam int PC_W      = 32;
  localparam int VICTIM_W  = 4;

  // pc remainder unit: bits folded per cycle
  localparam int MOD_STEP = 4;
  localparam int MOD_CYC  = PC_W / MOD_STEP;

  // request modes
  localparam logic MODE_VICTIM = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // re-reference values
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;

  // signature counters
  localparam logic [1:0] CTR_MIN  = 2'd0;
  localparam logic [1:0] CTR_INIT = 2'd1;
  localparam logic [1:0] CTR_MAX  = 2'd3;

endpackage

@@ src/ship_rrip_if.sv @@
interface ship_rrip_req_if;
  import ship_rrip_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_IN_W-1:0]  way;
  logic                 hit;
  logic [PC_W-1:0]      pc;

  modport source (output valid, mode, set_index, way, hit, pc, input ready);
  modport sink (input valid, mode, set_index, way, hit, pc, output ready);
endinterface

interface ship_rrip_rsp_if;
  import ship_rrip_pkg::*;

  logic                valid;
  logic                ready;
  logic [VICTIM_W-1:0] victim_way;
  logic                is_victim;

  modport source (output valid, victim_way, is_victim, input ready);
  modport sink (input valid, victim_way, is_victim, output ready);
endinterface

@@ src/ship_rrip_replacement_unit.sv @@
// Sequence: a victim request reads the set row (S_ROW), then registers its result; a hit or fill
//   update also reads the signature counter (S_CNT) after the set row read, then registers it.
// Fills with a non-power-of-two counter table first fold the pc remainder (S_MOD), then read (S_RD).
// Items: one at a time; the next item is taken the cycle after a result
//   is registered, and a result waits while the response output is held.
// Reset (rst, synchronous): clearing pass over every set row and counter entry, req.ready low.
module ship_rrip_replacement_unit #(
  parameter int SETS         = ship_rrip_pkg::DEF_SETS,
  parameter int WAYS         = ship_rrip_pkg::DEF_WAYS,
  parameter int SHCT_ENTRIES = ship_rrip_pkg::DEF_SHCT_ENTRIES
) (
  input logic           clk,
  input logic           rst,
  ship_rrip_req_if.sink   req,
  ship_rrip_rsp_if.source rsp
);
  import ship_rrip_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = $clog2(WAYS);
  localparam int SIG_W = $clog2(SHCT_ENTRIES);

  // counter table index is a plain mask when the table size is a power of two
  localparam bit SIG_POW2 = (SHCT_ENTRIES & (SHCT_ENTRIES - 1)) == 0;
  // set index needs a real wrap for a single set, or below 2**SET_IDX_W and off powers of two
  localparam bit SET_LOOP = (SETS == 1) ||
                            ((SETS < (1 << SET_IDX_W)) && ((SETS & (SETS - 1)) != 0));

  localparam int CLR_LEN = (SETS > SHCT_ENTRIES) ? SETS : SHCT_ENTRIES;
  localparam int CLR_W   = $clog2(CLR_LEN);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_LEN - 1);

  // sequencer
  localparam logic [2:0] S_CLEAR = 3'd0;  // reset sweep over both memories
  localparam logic [2:0] S_IDLE  = 3'd1;  // take an item, launch reads
  localparam logic [2:0] S_MOD   = 3'd2;  // pc remainder for a fill
  localparam logic [2:0] S_RD    = 3'd3;  // launch reads from captured item
  localparam logic [2:0] S_ROW   = 3'd4;  // set row in hand
  localparam logic [2:0] S_CNT   = 3'd5;  // signature counters in hand

  // one memory row holds the whole set
  typedef struct packed {
    logic [WAYS-1:0]            reused;
    logic [WAYS-1:0][SIG_W-1:0] sig;
    logic [WAYS-1:0][1:0]       rrpv;
  } row_t;

  localparam row_t ROW_CLEAR = '{reused: '0, sig: '0, rrpv: {WAYS{RRPV_DISTANT}}};

  row_t       row_mem [SETS];
  logic [1:0] cnt_mem [SHCT_ENTRIES];

  // state and captured item
  logic [2:0]       state, state_next;
  logic [CLR_W-1:0] clr_cnt;
  logic             q_mode;
  logic [SET_W-1:0] q_set;
  logic [WAY_IN_W-1:0] q_way;
  logic             q_hit;
  logic [SIG_W-1:0] q_fresh;

  // memory read data
  row_t       row_q;
  logic [1:0] cnt_a_q;
  logic [1:0] cnt_b_q;

  // result register
  logic                out_valid;
  logic [VICTIM_W-1:0] out_victim_way;
  logic                out_is_victim;

  // memory port controls
  logic             row_rd_en, row_we;
  logic [SET_W-1:0] row_rd_addr, row_wr_addr;
  row_t             row_wr_data;
  logic             cnt_a_en, cnt_b_en, cnt_we;
  logic [SIG_W-1:0] cnt_a_addr, cnt_b_addr, cnt_wr_addr;
  logic [1:0]       cnt_wr_data;

  logic             accept, out_free, finish;
  logic [SET_W-1:0] set_in;
  logic [SIG_W-1:0] fresh_in;
  logic             md_done;
  logic [SIG_W-1:0] md_rem;

  logic             way_ok;
  logic [WAY_W-1:0] way_idx;
  logic [1:0]       top;
  logic [WAY_W-1:0] best;
  row_t             row_aged;
  row_t             row_upd;
  logic [SIG_W-1:0] old_sig;
  logic [1:0]       cnt_new;
  logic [1:0]       fresh_ctr;

  // set index wrap by compare and subtract, one input bit a step
  function automatic logic [SET_W-1:0] set_wrap(input logic [SET_IDX_W-1:0] s);
    logic [SET_IDX_W:0] r;
    r = '0;
    for (int i = SET_IDX_W - 1; i >= 0; i--) begin
      r = {r[SET_IDX_W-1:0], s[i]};
      if (r >= (SET_IDX_W + 1)'(SETS)) begin
        r = r - (SET_IDX_W + 1)'(SETS);
      end
    end
    return SET_W'(r);
  endfunction

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;
  assign set_in    = SET_LOOP ? set_wrap(req.set_index) : SET_W'(req.set_index);

  assign rsp.valid      = out_valid;
  assign rsp.victim_way = out_victim_way;
  assign rsp.is_victim  = out_is_victim;

  // new signature: pc modulo the counter table size
  if (SIG_POW2) begin : g_fresh_mask
    assign fresh_in = req.pc[SIG_W-1:0];
    assign md_done  = 1'b1;
    assign md_rem   = '0;
  end else begin : g_fresh_div
    localparam int MC_W = $clog2(MOD_CYC);
    localparam logic [MC_W-1:0] MC_LAST = MC_W'(MOD_CYC - 1);

    logic [PC_W-1:0]  md_pc;
    logic [SIG_W-1:0] md_acc, acc_step;
    logic [MC_W-1:0]  md_cnt;

    // restoring remainder, MOD_STEP pc bits per cycle, msb first
    always_comb begin
      logic [SIG_W:0]  w;
      logic [PC_W-1:0] p;
      acc_step = md_acc;
      p        = md_pc;
      for (int i = 0; i < MOD_STEP; i++) begin
        w = {acc_step, p[PC_W-1]};
        p = p << 1;
        if (w >= (SIG_W + 1)'(SHCT_ENTRIES)) begin
          w = w - (SIG_W + 1)'(SHCT_ENTRIES);
        end
        acc_step = w[SIG_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        md_pc  <= req.pc;
        md_acc <= '0;
        md_cnt <= '0;
      end else begin
        md_pc  <= md_pc << MOD_STEP;
        md_acc <= acc_step;
        md_cnt <= md_cnt + MC_W'(1);
      end
    end

    assign fresh_in = '0;
    assign md_done  = (md_cnt == MC_LAST);
    assign md_rem   = acc_step;
  end

  // victim search: largest RRPV, first way holding it, age all ways up to 3
  always_comb begin
    logic [3:0] seen;
    logic       found;
    logic [1:0] add;
    seen = '0;
    for (int w = 0; w < WAYS; w++) begin
      seen[row_q.rrpv[w]] = 1'b1;
    end
    if (seen[3]) begin
      top = 2'd3;
    end else if (seen[2]) begin
      top = 2'd2;
    end else if (seen[1]) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
    add      = RRPV_DISTANT - top;
    row_aged = row_q;
    best     = '0;
    found    = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      row_aged.rrpv[w] = row_q.rrpv[w] + add;
      if (!found && row_q.rrpv[w] == top) begin
        best  = WAY_W'(w);
        found = 1'b1;
      end
    end
  end

  // hit / fill line update
  assign way_ok  = int'(q_way) < WAYS;
  assign way_idx = WAY_W'(q_way);
  assign old_sig = row_q.sig[way_idx];

  always_comb begin
    row_upd   = row_q;
    cnt_new   = cnt_a_q;
    fresh_ctr = cnt_b_q;
    if (q_hit) begin
      if (cnt_a_q != CTR_MAX) begin
        cnt_new = cnt_a_q + 2'd1;
      end
      row_upd.rrpv[way_idx]   = RRPV_NEAR;
      row_upd.reused[way_idx] = 1'b1;
    end else begin
      if (!row_q.reused[way_idx] && cnt_a_q != CTR_MIN) begin
        cnt_new = cnt_a_q - 2'd1;
      end
      // the old counter is lowered before the new one is looked at
      if (q_fresh == old_sig) begin
        fresh_ctr = cnt_new;
      end
      row_upd.reused[way_idx] = 1'b0;
      row_upd.sig[way_idx]    = q_fresh;
      row_upd.rrpv[way_idx]   = (fresh_ctr == CTR_MIN) ? RRPV_DISTANT : RRPV_LONG;
    end
  end

  // sequencer and memory port steering
  always_comb begin
    state_next  = state;
    finish      = 1'b0;
    row_rd_en   = 1'b0;
    row_rd_addr = q_set;
    row_we      = 1'b0;
    row_wr_addr = q_set;
    row_wr_data = row_upd;
    cnt_a_en    = 1'b0;
    cnt_a_addr  = old_sig;
    cnt_b_en    = 1'b0;
    cnt_b_addr  = q_fresh;
    cnt_we      = 1'b0;
    cnt_wr_addr = old_sig;
    cnt_wr_data = cnt_new;
    case (state)
      S_CLEAR: begin
        row_we      = int'(clr_cnt) < SETS;
        row_wr_addr = clr_cnt[SET_W-1:0];
        row_wr_data = ROW_CLEAR;
        cnt_we      = int'(clr_cnt) < SHCT_ENTRIES;
        cnt_wr_addr = clr_cnt[SIG_W-1:0];
        cnt_wr_data = CTR_INIT;
        if (clr_cnt == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!SIG_POW2 && req.mode == MODE_UPDATE && !req.hit) begin
            state_next = S_MOD;
          end else begin
            row_rd_en   = 1'b1;
            row_rd_addr = set_in;
            cnt_b_en    = 1'b1;
            cnt_b_addr  = fresh_in;
            state_next  = S_ROW;
          end
        end
      end
      S_MOD: begin
        if (md_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        row_rd_en  = 1'b1;
        cnt_b_en   = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        if (q_mode == MODE_VICTIM) begin
          finish = 1'b1;
          if (out_free) begin
            row_we      = 1'b1;
            row_wr_data = row_aged;
            state_next  = S_IDLE;
          end
        end else if (!way_ok) begin
          // way beyond the set: acknowledge only
          finish = 1'b1;
          if (out_free) begin
            state_next = S_IDLE;
          end
        end else begin
          cnt_a_en   = 1'b1;
          state_next = S_CNT;
        end
      end
      S_CNT: begin
        finish = 1'b1;
        if (out_free) begin
          row_we     = 1'b1;
          cnt_we     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // set rows: one read, one write port
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wr_addr] <= row_wr_data;
    end
    if (row_rd_en) begin
      row_q <= row_mem[row_rd_addr];
    end
  end

  // signature counters: two reads (old, new signature), one write
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    if (cnt_a_en) begin
      cnt_a_q <= cnt_mem[cnt_a_addr];
    end
    if (cnt_b_en) begin
      cnt_b_q <= cnt_mem[cnt_b_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (finish && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // captured item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mode  <= req.mode;
      q_set   <= set_in;
      q_way   <= req.way;
      q_hit   <= req.hit;
      q_fresh <= fresh_in;
    end else if (state == S_MOD && md_done) begin
      q_fresh <= md_rem;
    end
    if (finish && out_free) begin
      out_victim_way <= (q_mode == MODE_VICTIM) ? VICTIM_W'(best) : '0;
      out_is_victim  <= (q_mode == MODE_VICTIM);
    end
  end

endmodule
